### rtl/core/cle_pkg.sv
// Shared types and constants for the console line editor.
// Holds the controller states, the decoded byte kinds and the event code set.
// No dependencies.
package cle_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LEFT   = 3'd0;
    localparam logic [2:0] CFG_RIGHT  = 3'd1;
    localparam logic [2:0] CFG_DELETE = 3'd2;
    localparam logic [2:0] CFG_INTR   = 3'd3;
    localparam logic [2:0] CFG_QUIT   = 3'd4;

    // Reset values of the event codes.
    localparam logic [7:0] RST_LEFT   = 8'h02;
    localparam logic [7:0] RST_RIGHT  = 8'h06;
    localparam logic [7:0] RST_DELETE = 8'h7f;
    localparam logic [7:0] RST_INTR   = 8'h03;
    localparam logic [7:0] RST_QUIT   = 8'h04;

    // Printable range and fixed echo characters.
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7e;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] del;
        logic [7:0] intr;
        logic [7:0] quit;
    } t_codes;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_DELETE,
        CMD_INTR,
        CMD_QUIT
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_PUT,
        S_FIRST,
        S_SECOND,
        S_TAIL_RD,
        S_TAIL_EM,
        S_SPACE,
        S_LEFTS
    } t_state;

endpackage

### rtl/core/cle_in_if.sv
// Request channel carrying one received console byte.
// Depends on nothing.
interface cle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

### rtl/core/cle_out_if.sv
// Request channel carrying one echo byte and its end-of-echo flag.
// Depends on nothing.
interface cle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_echo;

    modport source (output valid, output out_byte, output last_echo, input ready);
    modport sink   (input valid, input out_byte, input last_echo, output ready);
endinterface

### rtl/core/cle_decode.sv
// Classifies a received byte against the printable range and the event codes.
// Depends on cle_pkg.
module cle_decode (
    input  logic [7:0]      i_byte,
    input  cle_pkg::t_codes i_codes,
    output cle_pkg::t_cmd   o_cmd
);

    // The printable range wins over any code; among codes, the first match wins.
    always_comb begin
        if (i_byte inside {[cle_pkg::PRINT_LO:cle_pkg::PRINT_HI]}) begin
            o_cmd = cle_pkg::CMD_INSERT;
        end else if (i_byte == i_codes.left) begin
            o_cmd = cle_pkg::CMD_LEFT;
        end else if (i_byte == i_codes.right) begin
            o_cmd = cle_pkg::CMD_RIGHT;
        end else if (i_byte == i_codes.del) begin
            o_cmd = cle_pkg::CMD_DELETE;
        end else if (i_byte == i_codes.intr) begin
            o_cmd = cle_pkg::CMD_INTR;
        end else if (i_byte == i_codes.quit) begin
            o_cmd = cle_pkg::CMD_QUIT;
        end else begin
            o_cmd = cle_pkg::CMD_NONE;
        end
    end

endmodule

### rtl/core/console_line_editor.sv
// Console line editor: a left, right, interrupt, quit or tail-less delete request goes
// from idle straight to its first echo byte. An insert writes its byte into the line
// memory before its echo, and an insert or delete with a tail first shifts each tail byte
// (line length minus cursor) with a read and a write; a redrawn tail is read back byte by
// byte after a tail read setup. Every echo byte can be held by output stalls. Only one
// request is in work at a time; the output register lets the next one start while
// the last echo byte waits. Reset clears length, cursor and output and loads reset codes.
// Depends on cle_pkg, cle_in_if, cle_out_if and cle_decode.
module console_line_editor #(
    parameter int LINE_MAX = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    cle_in_if.sink      i_in,
    cle_out_if.source   o_out
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int LW = $clog2(LINE_MAX + 1);

    cle_pkg::t_state r_state, n_state;
    cle_pkg::t_codes r_codes;
    cle_pkg::t_cmd   cmd;

    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_cur, n_cur;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;

    logic [7:0]    r_first, n_first;
    logic [7:0]    r_second, n_second;
    logic          r_has_second, n_has_second;
    logic [LW-1:0] r_mv_dst, n_mv_dst;
    logic          r_mv_up, n_mv_up;
    logic [LW-1:0] r_mv_cnt, n_mv_cnt;
    logic [LW-1:0] r_ins_pos, n_ins_pos;
    logic [LW-1:0] r_tp, n_tp;
    logic [LW-1:0] r_tend, n_tend;
    logic          r_space, n_space;
    logic [LW-1:0] r_lefts, n_lefts;

    logic [7:0]    r_mem [LINE_MAX];
    logic [7:0]    r_rdata;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;

    logic          out_free;
    logic [LW-1:0] tp_nx;
    logic [LW-1:0] tail_n;

    cle_decode u_decode (
        .i_byte  (i_in.in_byte),
        .i_codes (r_codes),
        .o_cmd   (cmd)
    );

    assign i_in.ready      = (r_state == cle_pkg::S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.last_echo = r_out_last;

    assign out_free = !r_out_valid || o_out.ready;
    assign tp_nx    = r_tp + LW'(1);
    assign tail_n   = r_len - r_cur;

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_cur        = r_cur;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_first      = r_first;
        n_second     = r_second;
        n_has_second = r_has_second;
        n_mv_dst     = r_mv_dst;
        n_mv_up      = r_mv_up;
        n_mv_cnt     = r_mv_cnt;
        n_ins_pos    = r_ins_pos;
        n_tp         = r_tp;
        n_tend       = r_tend;
        n_space      = r_space;
        n_lefts      = r_lefts;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wa       = r_mv_dst[AW-1:0];
        mem_ra       = r_tp[AW-1:0];
        mem_wd       = r_rdata;

        case (r_state)
            cle_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_tp         = '0;
                    n_tend       = '0;
                    n_space      = 1'b0;
                    n_lefts      = '0;
                    n_has_second = 1'b0;
                    case (cmd)
                        cle_pkg::CMD_INSERT: begin
                            if (r_len != LW'(LINE_MAX)) begin
                                n_len     = r_len + LW'(1);
                                n_cur     = r_cur + LW'(1);
                                n_first   = i_in.in_byte;
                                n_ins_pos = r_cur;
                                n_tp      = r_cur + LW'(1);
                                n_tend    = r_len + LW'(1);
                                n_lefts   = tail_n;
                                n_mv_dst  = r_len;
                                n_mv_up   = 1'b0;
                                n_mv_cnt  = tail_n;
                                n_state   = (tail_n == '0) ? cle_pkg::S_PUT
                                                           : cle_pkg::S_MOVE_RD;
                            end
                        end
                        cle_pkg::CMD_LEFT: begin
                            if (r_cur != '0) begin
                                n_cur   = r_cur - LW'(1);
                                n_first = r_codes.left;
                                n_state = cle_pkg::S_FIRST;
                            end
                        end
                        cle_pkg::CMD_RIGHT: begin
                            if (r_cur < r_len) begin
                                n_cur   = r_cur + LW'(1);
                                n_first = r_codes.right;
                                n_state = cle_pkg::S_FIRST;
                            end
                        end
                        cle_pkg::CMD_DELETE: begin
                            if (r_cur != '0) begin
                                n_cur    = r_cur - LW'(1);
                                n_len    = r_len - LW'(1);
                                n_first  = r_codes.del;
                                n_tp     = r_cur - LW'(1);
                                n_tend   = r_len - LW'(1);
                                n_space  = (tail_n != '0);
                                n_lefts  = (tail_n != '0) ? tail_n + LW'(1) : '0;
                                n_mv_dst = r_cur - LW'(1);
                                n_mv_up  = 1'b1;
                                n_mv_cnt = tail_n;
                                n_state  = (tail_n == '0) ? cle_pkg::S_FIRST
                                                          : cle_pkg::S_MOVE_RD;
                            end
                        end
                        cle_pkg::CMD_INTR: begin
                            n_first      = cle_pkg::CH_CARET;
                            n_second     = cle_pkg::CH_C;
                            n_has_second = 1'b1;
                            n_state      = cle_pkg::S_FIRST;
                        end
                        cle_pkg::CMD_QUIT: begin
                            n_first      = cle_pkg::CH_CARET;
                            n_second     = cle_pkg::CH_D;
                            n_has_second = 1'b1;
                            n_state      = cle_pkg::S_FIRST;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Each moved byte is read in S_MOVE_RD and written in S_MOVE_WR.
            cle_pkg::S_MOVE_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_mv_up ? AW'(r_mv_dst + LW'(1)) : AW'(r_mv_dst - LW'(1));
                n_state = cle_pkg::S_MOVE_WR;
            end

            cle_pkg::S_MOVE_WR: begin
                mem_we   = 1'b1;
                mem_wa   = r_mv_dst[AW-1:0];
                mem_wd   = r_rdata;
                n_mv_dst = r_mv_up ? r_mv_dst + LW'(1) : r_mv_dst - LW'(1);
                n_mv_cnt = r_mv_cnt - LW'(1);
                if (r_mv_cnt == LW'(1)) begin
                    n_state = r_mv_up ? cle_pkg::S_FIRST : cle_pkg::S_PUT;
                end else begin
                    n_state = cle_pkg::S_MOVE_RD;
                end
            end

            cle_pkg::S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_ins_pos[AW-1:0];
                mem_wd  = r_first;
                n_state = cle_pkg::S_FIRST;
            end

            cle_pkg::S_FIRST: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_first;
                    n_out_last  = !r_has_second && (r_tp == r_tend) && !r_space
                                  && (r_lefts == '0);
                    if (r_has_second) begin
                        n_state = cle_pkg::S_SECOND;
                    end else if (r_tp != r_tend) begin
                        n_state = cle_pkg::S_TAIL_RD;
                    end else if (r_space) begin
                        n_state = cle_pkg::S_SPACE;
                    end else if (r_lefts != '0) begin
                        n_state = cle_pkg::S_LEFTS;
                    end else begin
                        n_state = cle_pkg::S_IDLE;
                    end
                end
            end

            cle_pkg::S_SECOND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_second;
                    n_out_last  = 1'b1;
                    n_state     = cle_pkg::S_IDLE;
                end
            end

            cle_pkg::S_TAIL_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_tp[AW-1:0];
                n_state = cle_pkg::S_TAIL_EM;
            end

            // The read of the next tail byte is issued as the current one leaves.
            cle_pkg::S_TAIL_EM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_rdata;
                    n_out_last  = (tp_nx == r_tend) && !r_space && (r_lefts == '0);
                    n_tp        = tp_nx;
                    if (tp_nx != r_tend) begin
                        mem_re = 1'b1;
                        mem_ra = tp_nx[AW-1:0];
                    end else if (r_space) begin
                        n_state = cle_pkg::S_SPACE;
                    end else if (r_lefts != '0) begin
                        n_state = cle_pkg::S_LEFTS;
                    end else begin
                        n_state = cle_pkg::S_IDLE;
                    end
                end
            end

            cle_pkg::S_SPACE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = cle_pkg::CH_SPACE;
                    n_out_last  = (r_lefts == '0);
                    n_state     = (r_lefts != '0) ? cle_pkg::S_LEFTS : cle_pkg::S_IDLE;
                end
            end

            cle_pkg::S_LEFTS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_codes.left;
                    n_out_last  = (r_lefts == LW'(1));
                    n_lefts     = r_lefts - LW'(1);
                    if (r_lefts == LW'(1)) begin
                        n_state = cle_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = cle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::S_IDLE;
            r_len       <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
            r_codes     <= '{left:  cle_pkg::RST_LEFT,  right: cle_pkg::RST_RIGHT,
                             del:   cle_pkg::RST_DELETE, intr: cle_pkg::RST_INTR,
                             quit:  cle_pkg::RST_QUIT};
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cle_pkg::CFG_LEFT:   r_codes.left  <= i_cfg_data;
                    cle_pkg::CFG_RIGHT:  r_codes.right <= i_cfg_data;
                    cle_pkg::CFG_DELETE: r_codes.del   <= i_cfg_data;
                    cle_pkg::CFG_INTR:   r_codes.intr  <= i_cfg_data;
                    cle_pkg::CFG_QUIT:   r_codes.quit  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_first      <= n_first;
        r_second     <= n_second;
        r_has_second <= n_has_second;
        r_mv_dst     <= n_mv_dst;
        r_mv_up      <= n_mv_up;
        r_mv_cnt     <= n_mv_cnt;
        r_ins_pos    <= n_ins_pos;
        r_tp         <= n_tp;
        r_tend       <= n_tend;
        r_space      <= n_space;
        r_lefts      <= n_lefts;
    end

    // Line memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

endmodule

### sim/tb_top.sv
// Self-checking testbench for console_line_editor: keystroke requests in, echo requests out.
// A predictor keeps its own line, cursor and event codes and queues the echo it expects.
// Depends on cle_pkg, cle_in_if, cle_out_if and the console_line_editor RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int LINE_MAX      = 16;
    // Worst request: 15 bytes shifted, an insert write, its echo bytes and a tail read setup.
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_PRINTS    = 40;
    // Index that maps to no register; a write to it must change nothing.
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_echo;
    } t_echo;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    cle_in_if  in_ch();
    cle_out_if out_ch();

    console_line_editor #(.LINE_MAX(LINE_MAX)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state: the edit line as the terminal should show it.
    logic [7:0]      line_buf [LINE_MAX];
    int              line_len;
    int              cursor;
    cle_pkg::t_codes codes;

    logic [7:0] keys_waiting [$];
    t_echo      echo_due [$];

    int   err_count = 0;
    int   send_pct  = 0;
    int   recv_pct  = 0;
    int   hold_left = 0;
    int   quiet     = 0;
    logic hold_start = 1'b0;

    task automatic report(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("tb_top: mismatch %0d: %s", err_count, what);
        end
    endtask

    // Applies one keystroke to the predicted line and queues the echo it causes.
    task automatic edit_line(input logic [7:0] key);
        logic [7:0] bytes_out [$];
        int         i;
        int         n;
        if (key >= cle_pkg::PRINT_LO && key <= cle_pkg::PRINT_HI) begin
            if (line_len < LINE_MAX) begin
                for (i = line_len; i > cursor; i--) begin
                    line_buf[i] = line_buf[i - 1];
                end
                line_buf[cursor] = key;
                line_len++;
                cursor++;
                bytes_out.push_back(key);
                for (i = cursor; i < line_len; i++) begin
                    bytes_out.push_back(line_buf[i]);
                end
                for (i = 0; i < line_len - cursor; i++) begin
                    bytes_out.push_back(codes.left);
                end
            end
        end else if (key == codes.left) begin
            if (cursor > 0) begin
                cursor--;
                bytes_out.push_back(codes.left);
            end
        end else if (key == codes.right) begin
            if (cursor < line_len) begin
                cursor++;
                bytes_out.push_back(codes.right);
            end
        end else if (key == codes.del) begin
            if (cursor > 0) begin
                cursor--;
                for (i = cursor; i + 1 < line_len; i++) begin
                    line_buf[i] = line_buf[i + 1];
                end
                line_len--;
                bytes_out.push_back(codes.del);
                n = line_len - cursor;
                // Redraw the tail, blank the old last column, then walk back.
                if (n > 0) begin
                    for (i = cursor; i < line_len; i++) begin
                        bytes_out.push_back(line_buf[i]);
                    end
                    bytes_out.push_back(cle_pkg::CH_SPACE);
                    for (i = 0; i <= n; i++) begin
                        bytes_out.push_back(codes.left);
                    end
                end
            end
        end else if (key == codes.intr) begin
            bytes_out.push_back(cle_pkg::CH_CARET);
            bytes_out.push_back(cle_pkg::CH_C);
        end else if (key == codes.quit) begin
            bytes_out.push_back(cle_pkg::CH_CARET);
            bytes_out.push_back(cle_pkg::CH_D);
        end
        foreach (bytes_out[k]) begin
            echo_due.push_back('{out_byte: bytes_out[k],
                                 last_echo: (k == bytes_out.size() - 1)});
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            cle_pkg::CFG_LEFT:   codes.left  = data;
            cle_pkg::CFG_RIGHT:  codes.right = data;
            cle_pkg::CFG_DELETE: codes.del   = data;
            cle_pkg::CFG_INTR:   codes.intr  = data;
            cle_pkg::CFG_QUIT:   codes.quit  = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_codes(input logic [7:0] l, input logic [7:0] r, input logic [7:0] d,
                             input logic [7:0] c, input logic [7:0] q);
        write_reg(cle_pkg::CFG_LEFT, l);
        write_reg(cle_pkg::CFG_RIGHT, r);
        write_reg(cle_pkg::CFG_DELETE, d);
        write_reg(cle_pkg::CFG_INTR, c);
        write_reg(cle_pkg::CFG_QUIT, q);
    endtask

    // Mostly typing and cursor editing with the current codes, plus some arbitrary bytes.
    task automatic queue_typing(input int count, input int type_pct);
        int k;
        int j;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < type_pct) begin
                keys_waiting.push_back(8'($urandom_range(cle_pkg::PRINT_HI,
                                                         cle_pkg::PRINT_LO)));
            end else begin
                j = $urandom_range(9);
                if (j < 3) begin
                    keys_waiting.push_back(codes.left);
                end else if (j < 5) begin
                    keys_waiting.push_back(codes.right);
                end else if (j < 8) begin
                    keys_waiting.push_back(codes.del);
                end else if (j == 8) begin
                    keys_waiting.push_back($urandom_range(1) ? codes.intr : codes.quit);
                end else begin
                    keys_waiting.push_back(8'($urandom_range(255)));
                end
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (keys_waiting.size() != 0 || in_ch.valid || echo_due.size() != 0) begin
            @(negedge i_clk);
        end
        // A request that echoes nothing may still be in work here.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_keys
        logic go;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                edit_line(in_ch.in_byte);
            end
            if (!in_ch.valid || in_ch.ready) begin
                go = keys_waiting.size() != 0 && $urandom_range(99) >= send_pct;
                if (go) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.in_byte <= keys_waiting.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : long_hold
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : check_echo
        t_echo want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (echo_due.size() == 0) begin
                    report($sformatf("echo %02h with nothing expected", out_ch.out_byte));
                end else begin
                    want = echo_due.pop_front();
                    if (out_ch.out_byte !== want.out_byte) begin
                        report($sformatf("out_byte %02h, expected %02h",
                                         out_ch.out_byte, want.out_byte));
                    end
                    if (out_ch.last_echo !== want.last_echo) begin
                        report($sformatf("last_echo %b, expected %b on byte %02h",
                                         out_ch.last_echo, want.last_echo, want.out_byte));
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet == STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin : run
        int k;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = cle_pkg::CFG_LEFT;
        i_cfg_data    = 8'h00;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        out_ch.ready  = 1'b0;
        codes         = '{left: cle_pkg::RST_LEFT, right: cle_pkg::RST_RIGHT,
                          del: cle_pkg::RST_DELETE, intr: cle_pkg::RST_INTR,
                          quit: cle_pkg::RST_QUIT};
        line_len      = 0;
        cursor        = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: events on an empty line, an ignored byte, edits in mid-line, then a
        // line filled from the head until an insert is dropped.
        keys_waiting = '{cle_pkg::RST_INTR, cle_pkg::RST_QUIT, cle_pkg::RST_LEFT,
                         cle_pkg::RST_RIGHT, cle_pkg::RST_DELETE, 8'hff,
                         cle_pkg::PRINT_LO, cle_pkg::PRINT_HI, cle_pkg::RST_DELETE,
                         cle_pkg::RST_LEFT, 8'h61, cle_pkg::RST_DELETE,
                         cle_pkg::RST_RIGHT, cle_pkg::RST_LEFT};
        for (k = 0; k < LINE_MAX; k++) begin
            keys_waiting.push_back(8'($urandom_range(cle_pkg::PRINT_HI, cle_pkg::PRINT_LO)));
        end
        wait_drained();

        queue_typing(25, 40);
        wait_drained();

        // Codes at both ends of the byte range; the unused index must be ignored.
        set_codes(8'h00, 8'hff, 8'h08, 8'h1b, 8'h80);
        write_reg(CFG_UNUSED, 8'h55);
        send_pct = 49;
        queue_typing(25, 35);
        wait_drained();

        // Clashes: a printable left code, and three registers sharing one value.
        set_codes(8'h41, 8'h05, 8'h05, 8'h05, 8'h7f);
        send_pct = 0;
        recv_pct = 49;
        queue_typing(25, 30);
        wait_drained();

        set_codes(8'hff, 8'h00, 8'h10, 8'hfe, 8'hfe);
        send_pct = 33;
        recv_pct = 33;
        queue_typing(25, 40);
        wait_drained();

        // The receiver stops for a long stretch while requests keep coming.
        set_codes(cle_pkg::RST_LEFT, cle_pkg::RST_RIGHT, cle_pkg::RST_DELETE,
                  cle_pkg::RST_INTR, cle_pkg::RST_QUIT);
        send_pct = 0;
        recv_pct = 0;
        @(posedge i_clk);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        queue_typing(25, 60);
        wait_drained();

        send_pct = 33;
        recv_pct = 33;
        queue_typing(20, 45);
        wait_drained();

        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
